// ===== hw/rtl/ukst_pkg.sv =====
// Shared types, codes and constants for the unique key slot table.
package ukst_pkg;

    localparam int ENTRIES_DEF  = 10;
    localparam int KEY_BITS_DEF = 64;
    localparam int OP_W         = 2;
    localparam int KEY_W        = 64;
    localparam int STATUS_W     = 3;
    localparam int SLOT_W       = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_LISTED    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_CMP  = 2'd1,
        SRC_FREE = 2'd2
    } slot_src_t;

    typedef struct packed {
        logic      load;
        logic      step;
        logic      track;
        logic      emit;
        status_t   emit_status;
        slot_src_t emit_src;
        logic      commit_ins;
        logic      commit_rem;
    } ukst_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic full;
        logic cmp_valid;
        logic cmp_hit;
        logic cmp_last;
        logic later;
    } ukst_sts_t;

endpackage

// ===== hw/rtl/ukst_ctrl.sv =====
// Controller state machine for the unique key slot table.
module ukst_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ukst_pkg::OP_W-1:0] op,
    input  ukst_pkg::ukst_sts_t       sts,
    output ukst_pkg::ukst_cmd_t       cmd
);
    import ukst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECIDE = 3'b010,
        S_SCAN   = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = op;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!sts.full)
                        begin
                            cmd.step   = 1'b1;
                            state_next = S_SCAN;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_FULL;
                            state_next      = S_IDLE;
                        end
                    end
                    OP_REMOVE, OP_LIST:
                    begin
                        if (!sts.count_zero)
                        begin
                            cmd.step   = 1'b1;
                            state_next = S_SCAN;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.out_free)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (sts.cmp_hit)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_DUP;
                                state_next      = S_IDLE;
                            end
                            else if (sts.cmp_last)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_INSERTED;
                                cmd.emit_src    = SRC_FREE;
                                cmd.commit_ins  = 1'b1;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                cmd.step  = 1'b1;
                                cmd.track = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (sts.cmp_hit)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_REMOVED;
                                cmd.emit_src    = SRC_CMP;
                                cmd.commit_rem  = 1'b1;
                                state_next      = S_IDLE;
                            end
                            else if (sts.cmp_last)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_NOT_FOUND;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                cmd.step = 1'b1;
                            end
                        end
                        OP_LIST:
                        begin
                            if (sts.cmp_valid)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_LISTED;
                                cmd.emit_src    = SRC_CMP;
                            end
                            if ((sts.cmp_valid && !sts.later) || sts.cmp_last)
                                state_next = S_IDLE;
                            else
                                cmd.step = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ukst_datapath.sv =====
// Datapath: key memory, valid bits, occupancy count, scan compare and result register.
module ukst_datapath
#(
    parameter int ENTRIES  = ukst_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = ukst_pkg::KEY_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ukst_pkg::ukst_cmd_t           cmd,
    output ukst_pkg::ukst_sts_t           sts,
    input  logic [ukst_pkg::KEY_W-1:0]    key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ukst_pkg::STATUS_W-1:0] status,
    output logic [ukst_pkg::SLOT_W-1:0]   slot,
    output logic [ukst_pkg::KEY_W-1:0]    slot_key,
    output logic                          last
);
    import ukst_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [KEY_BITS-1:0] key_mem [ENTRIES];
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] rd_data_reg;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    rd_idx_reg, cmp_idx_reg, free_idx_reg;
    logic                have_free_reg;
    logic [IDX_W-1:0]    free_sel, src_idx;
    logic [IDX_W:0]      slot_sum;
    logic [ENTRIES-1:0]  above;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [KEY_W-1:0]    slot_key_reg;
    logic                last_reg;

    assign free_sel = have_free_reg ? free_idx_reg : cmp_idx_reg;

    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
            above[j] = (IDX_W'(j) > cmp_idx_reg);
    end

    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (count_reg == FULL_CNT);
    assign sts.cmp_valid  = valid_reg[cmp_idx_reg];
    assign sts.cmp_hit    = valid_reg[cmp_idx_reg] && (rd_data_reg == key_reg);
    assign sts.cmp_last   = (cmp_idx_reg == LAST_IDX);
    assign sts.later      = |(valid_reg & above);

    // key store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit_ins)
            key_mem[free_sel] <= key_reg;
        if (cmd.step)
            rd_data_reg <= key_mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            key_reg <= key[KEY_BITS-1:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.commit_ins)
        begin
            valid_next[free_sel] = 1'b1;
            count_next           = count_reg + 1'b1;
        end
        else if (cmd.commit_rem)
        begin
            valid_next[cmp_idx_reg] = 1'b0;
            count_next              = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            free_idx_reg  <= '0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (cmd.load)
            begin
                rd_idx_reg    <= '0;
                have_free_reg <= 1'b0;
            end
            else
            begin
                if (cmd.track && !sts.cmp_valid && !have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                    free_idx_reg  <= cmp_idx_reg;
                end
                if (cmd.step)
                begin
                    rd_idx_reg  <= rd_idx_reg + 1'b1;
                    cmp_idx_reg <= rd_idx_reg;
                end
            end
        end
    end

    // result register
    assign src_idx  = (cmd.emit_src == SRC_FREE) ? free_sel : cmp_idx_reg;
    assign slot_sum = {1'b0, src_idx} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            slot_reg   <= (cmd.emit_src == SRC_NONE) ? '0 : SLOT_W'(slot_sum);
            if (cmd.emit_status == ST_LISTED)
            begin
                slot_key_reg <= KEY_W'(rd_data_reg);
                last_reg     <= !sts.later;
            end
            else
            begin
                slot_key_reg <= '0;
                last_reg     <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign slot_key  = slot_key_reg;
    assign last      = last_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy count differs from valid bits");

    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_ins |-> (!valid_reg[free_sel] && count_reg != FULL_CNT))
        else $error("insert into an occupied slot or full table");

    a_remove_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_rem |-> valid_reg[cmp_idx_reg])
        else $error("remove of a free slot");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result written over a pending transfer");

endmodule

// ===== hw/rtl/unique_key_slot_table.sv =====
// Top level of the unique key slot table: controller plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_stall  | op[1:0], key[63:0]
//  out     | out_valid / out_stall| status[2:0], slot[3:0], slot_key[63:0], last
//
// An item passes through the accept, decide and scan states, and no new item is
// taken until it ends; a list gives one transfer per occupied slot. The scan is set
// by the key memory's single registered read port, one slot a cycle unless stalled.
// Full, empty and unused-opcode cases finish in the decide state.
// rst_n clears the valid bits and count at once; keys are undefined until written.
// A stalled result holds the scan until the result register frees.
module unique_key_slot_table
#(
    parameter int ENTRIES  = ukst_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = ukst_pkg::KEY_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ukst_pkg::OP_W-1:0]     op,
    input  logic [ukst_pkg::KEY_W-1:0]    key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ukst_pkg::STATUS_W-1:0] status,
    output logic [ukst_pkg::SLOT_W-1:0]   slot,
    output logic [ukst_pkg::KEY_W-1:0]    slot_key,
    output logic                          last
);
    import ukst_pkg::*;

    ukst_cmd_t cmd;
    ukst_sts_t sts;

    ukst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    ukst_datapath
    #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot      (slot),
        .slot_key  (slot_key),
        .last      (last)
    );

endmodule

// ===== tb/unique_key_slot_table_test.sv =====
// Self-checking testbench for the unique key slot table: directed script, random traffic, predictor.
module unique_key_slot_table_test;
    import ukst_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_ITEMS = 500;
    localparam int          POOL_SIZE    = 14;
    localparam int          TAIL_CYCLES  = 3 * (ENTRIES_DEF + 2);
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MASK  = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS_DEF);

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    slot_key;
        logic                last;
    } result_t;

    typedef struct {
        logic [OP_W-1:0]   cmd;
        logic [KEY_W-1:0]  k;
        bit                typed;
        status_t           st;
        logic [SLOT_W-1:0] sl;
    } stim_row_t;

    typedef enum {FILLING, DRAINING, CHURN} workload_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       op       = '0;
    logic [KEY_W-1:0]      key      = '0;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [KEY_W-1:0]      slot_key;
    logic                  last;

    logic                  rx_stall = 1'b0;
    logic                  hold_off = 1'b0;
    bit                    tx_idle  = 1'b1;
    bit                    rx_idle  = 1'b1;

    // table image kept by the predictor
    logic                  tbl_used [ENTRIES_DEF];
    logic [KEY_W-1:0]      tbl_key  [ENTRIES_DEF];
    int unsigned           tbl_count;

    result_t               fresh[$];
    result_t               pending_results[$];
    result_t               head;
    stim_row_t             script[$];
    logic [KEY_W-1:0]      key_pool [POOL_SIZE];
    int unsigned           sent_count = 0;
    int unsigned           mismatches = 0;
    int unsigned           cycles     = 0;

    assign out_stall = rx_stall | hold_off;

    unique_key_slot_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot      (slot),
        .slot_key  (slot_key),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("unique_key_slot_table_test: errors");
            $finish;
        end
    end

    task report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // Applies one command to the table image and leaves its results in fresh.
    task table_apply(input logic [OP_W-1:0] cmd, input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        int               free_idx;
        int               hit_idx;
        int               top;
        result_t          r;
        fresh.delete();
        k        = raw & KEY_MASK;
        r        = '0;
        r.last   = 1'b1;
        free_idx = -1;
        hit_idx  = -1;
        top      = -1;
        for (int i = 0; i < ENTRIES_DEF; i++)
        begin
            if (!tbl_used[i] && free_idx < 0)
                free_idx = i;
            if (tbl_used[i] && tbl_key[i] == k && hit_idx < 0)
                hit_idx = i;
            if (tbl_used[i])
                top = i;
        end
        case (cmd)
            OP_INSERT:
            begin
                if (free_idx < 0)
                    r.status = ST_FULL;
                else if (hit_idx >= 0)
                    r.status = ST_DUP;
                else
                begin
                    tbl_used[free_idx] = 1'b1;
                    tbl_key[free_idx]  = k;
                    tbl_count++;
                    r.status = ST_INSERTED;
                    r.slot   = SLOT_W'(free_idx + 1);
                end
                fresh.push_back(r);
            end
            OP_REMOVE:
            begin
                if (tbl_count == 0)
                    r.status = ST_EMPTY;
                else if (hit_idx >= 0)
                begin
                    tbl_used[hit_idx] = 1'b0;
                    tbl_count--;
                    r.status = ST_REMOVED;
                    r.slot   = SLOT_W'(hit_idx + 1);
                end
                else
                    r.status = ST_NOT_FOUND;
                fresh.push_back(r);
            end
            OP_LIST:
            begin
                if (top < 0)
                begin
                    r.status = ST_EMPTY;
                    fresh.push_back(r);
                end
                else
                    for (int i = 0; i < ENTRIES_DEF; i++)
                        if (tbl_used[i])
                        begin
                            r.status   = ST_LISTED;
                            r.slot     = SLOT_W'(i + 1);
                            r.slot_key = tbl_key[i];
                            r.last     = (i == top);
                            fresh.push_back(r);
                        end
            end
            default: ;
        endcase
    endtask

    task send_item(input logic [OP_W-1:0] cmd, input logic [KEY_W-1:0] k, input bit typed,
                   input status_t st, input logic [SLOT_W-1:0] sl);
        int      gap;
        result_t r;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= cmd;
        key      <= k;
        do @(posedge clk); while (in_stall);
        table_apply(cmd, k);
        if (typed)
        begin
            r        = '0;
            r.status = st;
            r.slot   = sl;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end
        else
            foreach (fresh[i])
                pending_results.push_back(fresh[i]);
    endtask

    function void add_row(input logic [OP_W-1:0] cmd, input logic [KEY_W-1:0] k,
                          input bit typed, input status_t st, input logic [SLOT_W-1:0] sl);
        stim_row_t row;
        row.cmd   = cmd;
        row.k     = k;
        row.typed = typed;
        row.st    = st;
        row.sl    = sl;
        script.push_back(row);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d slot %0d key %h",
                                          status, slot, slot_key));
            else
            begin
                head = pending_results.pop_front();
                if (status !== head.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", status, head.status));
                if (slot !== head.slot)
                    report_mismatch($sformatf("slot %0d, wanted %0d", slot, head.slot));
                if (slot_key !== head.slot_key)
                    report_mismatch($sformatf("slot_key %h, wanted %h", slot_key, head.slot_key));
                if (last !== head.last)
                    report_mismatch($sformatf("last %b, wanted %b", last, head.last));
            end
        end
    end

    // result side: random stalls per transfer
    initial
    begin
        int hold;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            hold = rx_idle ? $urandom_range(0, 19) : 0;
            if (hold > 0)
            begin
                rx_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rx_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            taken++;
            if (taken % 50 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
        end
    end

    // long hold-off on the result side so the block backs up
    initial
    begin
        wait (sent_count >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [OP_W-1:0]  cmd;
        logic [KEY_W-1:0] k;
        workload_t        mix;
        int               step;
        int               roll;
        int               ins_pct;
        int               rem_pct;
        int               n;

        foreach (tbl_used[i])
        begin
            tbl_used[i] = 1'b0;
            tbl_key[i]  = '0;
        end
        tbl_count = 0;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};

        add_row(OP_REMOVE, 64'h0123_4567_89ab_cdef, 1, ST_EMPTY,     4'd0);
        add_row(OP_LIST,   64'h0,                   1, ST_EMPTY,     4'd0);
        add_row(OP_UNUSED, {KEY_W{1'b1}},           0, ST_INSERTED,  4'd0);
        add_row(OP_INSERT, 64'h0,                   1, ST_INSERTED,  4'd1);
        add_row(OP_INSERT, {KEY_W{1'b1}},           1, ST_INSERTED,  4'd2);
        add_row(OP_INSERT, 64'h0,                   1, ST_DUP,       4'd0);
        add_row(OP_LIST,   64'h0,                   0, ST_INSERTED,  4'd0);
        add_row(OP_REMOVE, 64'h5555_5555_aaaa_aaaa, 1, ST_NOT_FOUND, 4'd0);
        add_row(OP_REMOVE, 64'h0,                   1, ST_REMOVED,   4'd1);
        add_row(OP_INSERT, 64'h8000_0000_0000_0001, 1, ST_INSERTED,  4'd1);
        add_row(OP_INSERT, 64'h0000_0061_6c69_6365, 1, ST_INSERTED,  4'd3);
        add_row(OP_INSERT, 64'h0000_0000_0062_6f62, 1, ST_INSERTED,  4'd4);
        add_row(OP_INSERT, 64'h0000_6361_726f_6c65, 1, ST_INSERTED,  4'd5);
        add_row(OP_INSERT, 64'h0000_0000_6461_7665, 1, ST_INSERTED,  4'd6);
        add_row(OP_INSERT, 64'h0000_0000_0065_7665, 1, ST_INSERTED,  4'd7);
        add_row(OP_INSERT, 64'h0000_6672_616e_6b00, 1, ST_INSERTED,  4'd8);
        add_row(OP_INSERT, 64'h0067_7265_7461_6368, 1, ST_INSERTED,  4'd9);
        add_row(OP_INSERT, 64'h6865_6e72_6965_7474, 1, ST_INSERTED,  4'd10);
        add_row(OP_INSERT, 64'h7fff_ffff_ffff_fffe, 1, ST_FULL,      4'd0);
        add_row(OP_INSERT, {KEY_W{1'b1}},           1, ST_FULL,      4'd0);
        add_row(OP_LIST,   64'haaaa_5555_aaaa_5555, 0, ST_INSERTED,  4'd0);
        add_row(OP_REMOVE, {KEY_W{1'b1}},           1, ST_REMOVED,   4'd2);
        add_row(OP_INSERT, {KEY_W{1'b1}},           1, ST_INSERTED,  4'd2);
        add_row(OP_UNUSED, 64'h0,                   0, ST_INSERTED,  4'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].cmd, script[i].k, script[i].typed, script[i].st, script[i].sl);

        step = 0;
        mix  = CHURN;
        while (sent_count < RANDOM_ITEMS)
        begin
            if (step % 40 == 0)
            begin
                mix     = workload_t'($urandom_range(0, 2));
                tx_idle = ($urandom_range(0, 3) != 0);
            end
            step++;
            case (mix)
                FILLING:  begin ins_pct = 70; rem_pct = 15; end
                DRAINING: begin ins_pct = 15; rem_pct = 65; end
                default:  begin ins_pct = 40; rem_pct = 35; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                cmd = OP_INSERT;
            else if (roll < ins_pct + rem_pct)
                cmd = OP_REMOVE;
            else if (roll < 95)
                cmd = OP_LIST;
            else
                cmd = OP_UNUSED;

            // removes lean on keys known to be stored
            roll = $urandom_range(0, 99);
            k    = {$urandom, $urandom};
            if (cmd == OP_REMOVE && roll < 50 && tbl_count != 0)
            begin
                n = $urandom_range(0, tbl_count - 1);
                for (int i = 0; i < ENTRIES_DEF; i++)
                    if (tbl_used[i])
                    begin
                        if (n == 0)
                            k = tbl_key[i];
                        n--;
                    end
            end
            else if (roll < 85)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];

            send_item(cmd, k, 1'b0, ST_INSERTED, '0);
            if (cmd != OP_UNUSED)
                sent_count++;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("unique_key_slot_table_test: clean");
        else
            $display("unique_key_slot_table_test: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ukst_pkg.sv
hw/rtl/ukst_ctrl.sv
hw/rtl/ukst_datapath.sv
hw/rtl/unique_key_slot_table.sv
tb/unique_key_slot_table_test.sv
